FILE: hdl/atn16_pkg.sv
`timescale 1ns / 1ps

package atn16_pkg;

  // table geometry
  localparam int unsigned CAPACITY     = 16;
  localparam int unsigned HANDLE_WIDTH = 64;
  localparam int unsigned CNT_W        = $clog2(CAPACITY + 1);

  // beat field widths
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned KEY_W      = 8;
  localparam int unsigned IN_HDL_W   = 64;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned OUT_HDL_W  = 64;
  localparam int unsigned OUT_CNT_W  = 5;
  localparam int unsigned SHRINK_W   = 5;
  localparam int unsigned IN_DATA_W  = 80;
  localparam int unsigned OUT_DATA_W = 72;

  // width used when comparing the count against the shrink threshold
  localparam int unsigned THR_W = (CNT_W > SHRINK_W) ? CNT_W : SHRINK_W;

  typedef logic [KEY_W-1:0]        key_t;
  typedef logic [HANDLE_WIDTH-1:0] handle_t;
  typedef logic [CNT_W-1:0]        count_t;

  typedef enum logic [FUNC_W-1:0] {
    OP_INSERT  = 2'd0,
    OP_DELETE  = 2'd1,
    OP_REPLACE = 2'd2,
    OP_LOOKUP  = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_MISSING   = 2'd2,
    ST_DUPLICATE = 2'd3
  } status_e;

  // what a cell loads on the next edge
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD_NEW,
    CELL_LOAD_HANDLE,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT
  } cell_cmd_e;

  // compare result of one cell, already qualified by occupancy
  typedef struct packed {
    logic match;
    logic less;
  } cell_flags_t;

endpackage

FILE: hdl/atn16_cell.sv
`timescale 1ns / 1ps

module atn16_cell
  import atn16_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmp_en_i,
  input  logic        occupied_i,
  input  key_t        cmp_key_i,
  input  cell_cmd_e   cmd_i,
  input  key_t        new_key_i,
  input  handle_t     new_handle_i,
  input  key_t        left_key_i,
  input  handle_t     left_handle_i,
  input  key_t        right_key_i,
  input  handle_t     right_handle_i,
  output key_t        key_o,
  output handle_t     handle_o,
  output cell_flags_t flags_o
);

  key_t        key_q, key_d;
  handle_t     handle_q, handle_d;
  cell_flags_t flags_q, flags_d;

  always_comb begin
    key_d    = key_q;
    handle_d = handle_q;
    case (cmd_i)
      CELL_HOLD: begin
      end
      CELL_LOAD_NEW: begin
        key_d    = new_key_i;
        handle_d = new_handle_i;
      end
      CELL_LOAD_HANDLE: begin
        handle_d = new_handle_i;
      end
      CELL_FROM_LEFT: begin
        key_d    = left_key_i;
        handle_d = left_handle_i;
      end
      CELL_FROM_RIGHT: begin
        key_d    = right_key_i;
        handle_d = right_handle_i;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    flags_d = flags_q;
    if (cmp_en_i) begin
      flags_d.match = occupied_i && (key_q == cmp_key_i);
      flags_d.less  = occupied_i && (key_q < cmp_key_i);
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    handle_q <= handle_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else begin
      flags_q <= flags_d;
    end
  end

  assign key_o    = key_q;
  assign handle_o = handle_q;
  assign flags_o  = flags_q;

endmodule

FILE: hdl/sorted_sixteen_entry_child_table.sv
`timescale 1ns / 1ps
// the result beat follows the input beat through a compare step, then a shift/commit step
// a new request is accepted only after the previous one has been committed to the cell row
// the commit cycle waits while an earlier result beat is still held at the output
// reset: asynchronous, active low; table empty, shrink threshold 4, no result pending
// entry contents are not cleared by reset, only entries below the count are ever read
module sorted_sixteen_entry_child_table
  import atn16_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration: shrink threshold
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [SHRINK_W-1:0]   cfg_data_i,
  // request beats
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // [1:0] func, [9:2] key_byte, [73:10] child_handle, [79:74] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // result beats
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // [1:0] status, [65:2] result_handle, [70:66] entry_count, [71] shrink_needed
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  // two-state sequencer: wait for a request, then commit it to the row
  typedef enum logic {
    S_IDLE,
    S_APPLY
  } state_e;

  state_e              state_q;
  op_e                 op_q;
  key_t                key_q;
  handle_t             handle_q;
  count_t              count_q, count_d;
  logic [SHRINK_W-1:0] shrink_below_q;

  logic                 out_valid_q;
  status_e              out_status_q, out_status_d;
  logic [OUT_HDL_W-1:0] out_handle_q, out_handle_d;
  logic [OUT_CNT_W-1:0] out_count_q;
  logic                 out_shrink_q, out_shrink_d;

  logic accept;
  logic commit;

  // row of cells and their neighbour links
  key_t        cell_key    [CAPACITY];
  handle_t     cell_handle [CAPACITY];
  cell_flags_t cell_flags  [CAPACITY];
  cell_cmd_e   cell_cmd    [CAPACITY];
  logic        occupied    [CAPACITY];

  logic    found;
  logic    insert_ok;
  logic    delete_ok;
  handle_t hit_handle;

  // request fields
  op_e     in_op;
  key_t    in_key;
  handle_t in_handle;

  assign in_op     = op_e'(s_axis_tdata_i[FUNC_W-1:0]);
  assign in_key    = s_axis_tdata_i[FUNC_W +: KEY_W];
  assign in_handle = s_axis_tdata_i[FUNC_W + KEY_W +: HANDLE_WIDTH];

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  // commit once the output register is free or being drained this cycle
  assign commit          = (state_q == S_APPLY) && (!out_valid_q || m_axis_tready_i);
  assign cfg_ready_o     = 1'b1;

  // cell chain: each cell sees its left and right neighbour, row ends loop onto themselves
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign occupied[i] = (CNT_W'(i) < count_q);

    atn16_cell u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .cmp_en_i       (accept),
      .occupied_i     (occupied[i]),
      .cmp_key_i      (in_key),
      .cmd_i          (cell_cmd[i]),
      .new_key_i      (key_q),
      .new_handle_i   (handle_q),
      .left_key_i     (cell_key[(i == 0) ? i : i - 1]),
      .left_handle_i  (cell_handle[(i == 0) ? i : i - 1]),
      .right_key_i    (cell_key[(i == CAPACITY - 1) ? i : i + 1]),
      .right_handle_i (cell_handle[(i == CAPACITY - 1) ? i : i + 1]),
      .key_o          (cell_key[i]),
      .handle_o       (cell_handle[i]),
      .flags_o        (cell_flags[i])
    );
  end

  // hit detection and handle of the matching cell (at most one matches)
  always_comb begin
    found      = 1'b0;
    hit_handle = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      found      = found | cell_flags[i].match;
      hit_handle = hit_handle | (cell_flags[i].match ? cell_handle[i] : '0);
    end
  end

  assign insert_ok = (op_q == OP_INSERT) && !found && (count_q < CNT_W'(CAPACITY));
  assign delete_ok = (op_q == OP_DELETE) && found;

  // per-cell command; the less flags form a prefix because the row is sorted
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_cmd[i] = CELL_HOLD;
      if (commit) begin
        if (insert_ok) begin
          if (cell_flags[i].less) begin
            cell_cmd[i] = CELL_HOLD;
          end else if (i == 0) begin
            cell_cmd[i] = CELL_LOAD_NEW;
          end else if (cell_flags[(i == 0) ? 0 : i - 1].less) begin
            cell_cmd[i] = CELL_LOAD_NEW;
          end else begin
            cell_cmd[i] = CELL_FROM_LEFT;
          end
        end else if (delete_ok) begin
          // the hit cell and every larger key close the gap
          cell_cmd[i] = cell_flags[i].less ? CELL_HOLD : CELL_FROM_RIGHT;
        end else if ((op_q == OP_REPLACE) && cell_flags[i].match) begin
          cell_cmd[i] = CELL_LOAD_HANDLE;
        end
      end
    end
  end

  // result fields and next count
  always_comb begin
    count_d      = count_q;
    out_status_d = ST_OK;
    out_handle_d = '0;
    out_shrink_d = 1'b0;
    case (op_q)
      OP_INSERT: begin
        if (found) begin
          out_status_d = ST_DUPLICATE;
        end else if (!insert_ok) begin
          out_status_d = ST_FULL;
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end
      OP_DELETE: begin
        if (!found) begin
          out_status_d = ST_MISSING;
        end else begin
          count_d      = count_q - CNT_W'(1);
          out_handle_d = OUT_HDL_W'(hit_handle);
          out_shrink_d = (THR_W'(count_d) < THR_W'(shrink_below_q));
        end
      end
      OP_REPLACE: begin
        if (!found) begin
          out_status_d = ST_MISSING;
        end
      end
      OP_LOOKUP: begin
        if (!found) begin
          out_status_d = ST_MISSING;
        end else begin
          out_handle_d = OUT_HDL_W'(hit_handle);
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer, count, threshold and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      count_q        <= '0;
      shrink_below_q <= SHRINK_W'(4);
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        shrink_below_q <= cfg_data_i;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_APPLY;
          end
          if (m_axis_tready_i) begin
            out_valid_q <= 1'b0;
          end
        end
        S_APPLY: begin
          if (commit) begin
            state_q     <= S_IDLE;
            count_q     <= count_d;
            out_valid_q <= 1'b1;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= in_op;
      key_q    <= in_key;
      handle_q <= in_handle;
    end
    if (commit) begin
      out_status_q <= out_status_d;
      out_handle_q <= out_handle_d;
      out_count_q  <= OUT_CNT_W'(count_d);
      out_shrink_q <= out_shrink_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_shrink_q, out_count_q, out_handle_q, out_status_q};

endmodule
